@@ sv/assert_macros.svh @@
// Assertion helpers used by the checker of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ sv/lwsp_pkg.sv @@
package lwsp_pkg;

  localparam int unsigned CoordW  = 8;
  localparam int unsigned PixelW  = 16;
  localparam int unsigned WordW   = 32;
  localparam int unsigned CornerW = 10;
  localparam int unsigned CfgW    = 8;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned IdxW    = 4;

  localparam logic [CoordW-1:0] CmdWinX0   = 8'h12;
  localparam logic [CoordW-1:0] CmdWinY0   = 8'h13;
  localparam logic [CoordW-1:0] CmdWinX1   = 8'h15;
  localparam logic [CoordW-1:0] CmdWinY1   = 8'h16;
  localparam logic [CoordW-1:0] CmdHorzWin = 8'h44;
  localparam logic [CoordW-1:0] CmdVertWin = 8'h45;
  localparam logic [CoordW-1:0] CmdCursor  = 8'h21;
  localparam logic [CoordW-1:0] CmdDraw    = 8'h22;
  localparam logic [CoordW-1:0] ByteZero   = 8'h00;

  localparam logic [IdxW-1:0] LastIdxTwoByte  = 4'd7;
  localparam logic [IdxW-1:0] LastIdxFourByte = 4'd13;

  localparam logic [CoordW-1:0] PanelWidthRst = 8'd220;

  localparam logic KindRect  = 1'b0;
  localparam logic KindPixel = 1'b1;

  localparam logic PanelTwoByte  = 1'b0;
  localparam logic PanelFourByte = 1'b1;

  typedef enum logic [CfgIdxW-1:0] {
    REG_PANEL_TYPE   = 2'd0,
    REG_ROTATED_MODE = 2'd1,
    REG_PANEL_WIDTH  = 2'd2
  } cfg_reg_e;

  typedef logic signed [CornerW-1:0] corner_t;

  typedef struct packed {
    logic              kind;
    logic [CoordW-1:0] start_col;
    logic [CoordW-1:0] start_row;
    logic [CoordW-1:0] end_col;
    logic [CoordW-1:0] end_row;
    logic [PixelW-1:0] pixel_a;
    logic [PixelW-1:0] pixel_b;
  } in_item_t;

  typedef struct packed {
    logic              is_pixel;
    logic              high_select;
    logic [CoordW-1:0] bus_byte;
    logic [WordW-1:0]  pixel_word;
    logic              last;
  } out_item_t;

  typedef struct packed {
    logic              panel_type;
    logic              rotated_mode;
    logic [CoordW-1:0] panel_width;
  } cfg_t;

  typedef struct packed {
    corner_t c1;
    corner_t c2;
    corner_t c3;
    corner_t c4;
  } corners_t;

  function automatic logic [PixelW-1:0] swap16(input logic [PixelW-1:0] v);
    return {v[7:0], v[15:8]};
  endfunction

endpackage

@@ sv/lwsp_if.sv @@
interface lwsp_in_if;
  import lwsp_pkg::*;
  logic     valid;
  logic     ready;
  in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface lwsp_out_if;
  import lwsp_pkg::*;
  logic      valid;
  logic      ready;
  out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

@@ sv/lwsp_corner.sv @@
module lwsp_corner import lwsp_pkg::*; (
  input  in_item_t item_i,
  input  cfg_t     cfg_i,
  output corners_t raw_o,
  output corners_t ord_o
);

  corner_t sc, sr, ec, er, w;

  always_comb begin
    sc = $signed({2'b00, item_i.start_col});
    sr = $signed({2'b00, item_i.start_row});
    ec = $signed({2'b00, item_i.end_col});
    er = $signed({2'b00, item_i.end_row});
    w  = $signed({2'b00, cfg_i.panel_width});
    if (cfg_i.rotated_mode) begin
      raw_o.c1 = sr;
      raw_o.c2 = w - corner_t'(1) - sc;
      raw_o.c3 = er - corner_t'(1);
      raw_o.c4 = w - ec;
    end else begin
      raw_o.c1 = sc;
      raw_o.c2 = sr;
      raw_o.c3 = ec - corner_t'(1);
      raw_o.c4 = er - corner_t'(1);
    end
  end

  // order each pair so the smaller corner comes first
  always_comb begin
    if (raw_o.c3 < raw_o.c1) begin
      ord_o.c1 = raw_o.c3;
      ord_o.c3 = raw_o.c1;
    end else begin
      ord_o.c1 = raw_o.c1;
      ord_o.c3 = raw_o.c3;
    end
    if (raw_o.c4 < raw_o.c2) begin
      ord_o.c2 = raw_o.c4;
      ord_o.c4 = raw_o.c2;
    end else begin
      ord_o.c2 = raw_o.c2;
      ord_o.c4 = raw_o.c4;
    end
  end

endmodule

@@ sv/lwsp_seq.sv @@
module lwsp_seq import lwsp_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  cfg_t      cfg_i,
  lwsp_in_if.sink   in_i,
  input  logic      res_take_i,
  output logic      res_valid_o,
  output out_item_t res_o
);

  in_item_t        item_q;
  logic            hold_q;
  logic [IdxW-1:0] idx_q;
  corners_t        raw, ord;
  logic            advance;
  logic [1:0]      grp;
  logic [1:0]      phase;
  corner_t         sel_c;
  corner_t         hi_c;
  corner_t         lo_c;
  logic [CoordW-1:0] cmd;

  lwsp_corner u_corner (
    .item_i (item_q),
    .cfg_i  (cfg_i),
    .raw_o  (raw),
    .ord_o  (ord)
  );

  always_comb begin
    res_o       = '0;
    res_valid_o = hold_q;
    grp         = '0;
    phase       = '0;
    sel_c       = '0;
    hi_c        = '0;
    lo_c        = '0;
    cmd         = ByteZero;
    if (item_q.kind == KindPixel) begin
      res_o.is_pixel   = 1'b1;
      res_o.pixel_word = {swap16(item_q.pixel_b), swap16(item_q.pixel_a)};
      res_o.last       = 1'b1;
    end else if (cfg_i.panel_type == PanelTwoByte) begin
      grp = idx_q[2:1];
      case (grp)
        2'd0: begin cmd = CmdWinX0; sel_c = raw.c1; end
        2'd1: begin cmd = CmdWinY0; sel_c = raw.c2; end
        2'd2: begin cmd = CmdWinX1; sel_c = raw.c3; end
        default: begin cmd = CmdWinY1; sel_c = raw.c4; end
      endcase
      res_o.bus_byte = idx_q[0] ? sel_c[CoordW-1:0] : cmd;
      res_o.last     = (idx_q == LastIdxTwoByte);
    end else begin
      grp   = idx_q[3:2];
      phase = idx_q[1:0];
      case (grp)
        2'd0: begin cmd = CmdHorzWin; hi_c = ord.c3; lo_c = ord.c1; end
        2'd1: begin cmd = CmdVertWin; hi_c = ord.c4; lo_c = ord.c2; end
        2'd2: begin
          cmd  = CmdCursor;
          hi_c = cfg_i.rotated_mode ? ord.c4 : ord.c2;
          lo_c = ord.c1;
        end
        default: cmd = CmdDraw;
      endcase
      if (grp == 2'd3) begin
        res_o.bus_byte = phase[0] ? cmd : ByteZero;
      end else begin
        case (phase)
          2'd0: res_o.bus_byte = ByteZero;
          2'd1: res_o.bus_byte = cmd;
          2'd2: res_o.bus_byte = hi_c[CoordW-1:0];
          default: res_o.bus_byte = lo_c[CoordW-1:0];
        endcase
        res_o.high_select = phase[1];
      end
      res_o.last = (idx_q == LastIdxFourByte);
    end
  end

  assign advance    = hold_q && res_take_i;
  assign in_i.ready = !hold_q || (advance && res_o.last);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_q <= 1'b0;
      idx_q  <= '0;
    end else if (in_i.valid && in_i.ready) begin
      hold_q <= 1'b1;
      idx_q  <= '0;
    end else if (advance && res_o.last) begin
      hold_q <= 1'b0;
    end else if (advance) begin
      idx_q <= idx_q + IdxW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      item_q <= in_i.data;
    end
  end

endmodule

@@ sv/lcd_window_setup_pixel_pack.sv @@
// LCD window setup and pixel packing for a byte-wide command bus controller.
// Input channel in_i carries one transaction per item: a rectangle setup
// (kind 0) or a pixel pair (kind 1). Output channel out_o carries one
// transaction per result; last marks the final result of an item.
// A rectangle gives 8 low-strobe bus writes on panel type 0 and 14 writes
// (window, cursor and start-drawing commands) on panel type 1. A pixel pair
// gives one 32-bit byte-swapped word.
// The first result of an item reaches out_o once the sequencer has
// registered the item and the output register has loaded the result.
// Throughput: while out_o is not stalled, pixel pairs run at one per cycle
// and a rectangle holds the sequencer at one bus write per cycle; the next
// item is taken in the cycle its last write moves to the output register.
// Configuration (panel_type, rotated_mode, panel_width) is written by the
// user through cfg_we_i/cfg_idx_i/cfg_wdata_i only while the block is idle;
// the block does not enforce this. Reset clears both pipeline stages and
// loads panel_type 0, rotated_mode 0 and panel_width 220. When out_o.ready
// is low the output register holds its transaction and the sequencer
// stalls behind it; in_i.ready drops once the held item cannot retire.
module lcd_window_setup_pixel_pack import lwsp_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [CfgW-1:0]    cfg_wdata_i,
  lwsp_in_if.sink            in_i,
  lwsp_out_if.source         out_o
);

  cfg_t      cfg_q;
  logic      res_valid;
  logic      res_take;
  out_item_t res;
  logic      out_valid_q;
  out_item_t out_data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.panel_type   <= PanelTwoByte;
      cfg_q.rotated_mode <= 1'b0;
      cfg_q.panel_width  <= PanelWidthRst;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_PANEL_TYPE:   cfg_q.panel_type   <= cfg_wdata_i[0];
        REG_ROTATED_MODE: cfg_q.rotated_mode <= cfg_wdata_i[0];
        REG_PANEL_WIDTH:  cfg_q.panel_width  <= cfg_wdata_i[CoordW-1:0];
        default: ;
      endcase
    end
  end

  lwsp_seq u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .in_i        (in_i),
    .res_take_i  (res_take),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  assign res_take = !out_valid_q || out_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_take) begin
      out_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_take) begin
      out_data_q <= res;
    end
  end

  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_data_q;

endmodule

@@ sv/lwsp_chk.sv @@
`include "assert_macros.svh"

module lwsp_chk import lwsp_pkg::*; (
  input logic      clk_i,
  input logic      rst_ni,
  input logic      out_valid_i,
  input logic      out_ready_i,
  input out_item_t out_data_i
);

  `ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_i && !out_ready_i, out_valid_i && $stable(out_data_i), "stalled transaction changed")
  `ASSERT_IMPLY(a_pixel_fields, clk_i, rst_ni, out_valid_i && out_data_i.is_pixel, out_data_i.last && !out_data_i.high_select && (out_data_i.bus_byte == '0), "pixel result with bus fields set")
  `ASSERT_IMPLY(a_cmd_no_word, clk_i, rst_ni, out_valid_i && !out_data_i.is_pixel, out_data_i.pixel_word == '0, "bus write with pixel word set")
  `ASSERT_IMPLY(a_high_not_last, clk_i, rst_ni, out_valid_i && !out_data_i.is_pixel && out_data_i.high_select, !out_data_i.last, "high-strobe write marked last")

endmodule

bind lcd_window_setup_pixel_pack lwsp_chk u_lwsp_chk (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_data_i  (out_o.data)
);

@@ tb/tb_lcd_window_setup_pixel_pack.sv @@
module tb_lcd_window_setup_pixel_pack;
  import lwsp_pkg::*;

  typedef struct packed {
    logic             is_write;
    cfg_reg_e         reg_idx;
    logic [CfgW-1:0]  reg_val;
    in_item_t         item;
    logic             typed;
    logic [WordW-1:0] word;
  } step_t;

  logic               clk_i = 1'b0;
  logic               rst_ni;
  logic               cfg_we_i;
  logic [CfgIdxW-1:0] cfg_idx_i;
  logic [CfgW-1:0]    cfg_wdata_i;

  lwsp_in_if  in_if ();
  lwsp_out_if out_if ();

  lcd_window_setup_pixel_pack dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_i        (in_if),
    .out_o       (out_if)
  );

  cfg_t        panel_cfg;
  out_item_t   pending_writes [$];
  int unsigned mismatches = 0;
  int unsigned idle_pct = 0;
  int unsigned stall_pct = 0;
  step_t       dir_steps [25];

  always #10 clk_i = ~clk_i;

  always @(negedge clk_i) begin
    out_if.ready <= ($urandom_range(99) >= stall_pct);
  end

  function automatic void bus_write(input logic high, input logic [CoordW-1:0] value);
    out_item_t r;
    r = '0;
    r.high_select = high;
    r.bus_byte = value;
    pending_writes.push_back(r);
  endfunction

  function automatic void cmd_quad(input logic [CoordW-1:0] cmd, input int hi, input int lo);
    bus_write(1'b0, ByteZero);
    bus_write(1'b0, cmd);
    bus_write(1'b1, hi[7:0]);
    bus_write(1'b1, lo[7:0]);
  endfunction

  function automatic void lcd_writes_for(input in_item_t it);
    out_item_t r;
    int        w, c1, c2, c3, c4, t;
    if (it.kind == KindPixel) begin
      r = '0;
      r.is_pixel = 1'b1;
      r.pixel_word = {it.pixel_b[7:0], it.pixel_b[15:8], it.pixel_a[7:0], it.pixel_a[15:8]};
      r.last = 1'b1;
      pending_writes.push_back(r);
      return;
    end
    w = int'(panel_cfg.panel_width);
    if (panel_cfg.rotated_mode) begin
      c1 = int'(it.start_row);
      c2 = w - 1 - int'(it.start_col);
      c3 = int'(it.end_row) - 1;
      c4 = w - int'(it.end_col);
    end else begin
      c1 = int'(it.start_col);
      c2 = int'(it.start_row);
      c3 = int'(it.end_col) - 1;
      c4 = int'(it.end_row) - 1;
    end
    if (panel_cfg.panel_type == PanelTwoByte) begin
      bus_write(1'b0, CmdWinX0);
      bus_write(1'b0, c1[7:0]);
      bus_write(1'b0, CmdWinY0);
      bus_write(1'b0, c2[7:0]);
      bus_write(1'b0, CmdWinX1);
      bus_write(1'b0, c3[7:0]);
      bus_write(1'b0, CmdWinY1);
      bus_write(1'b0, c4[7:0]);
    end else begin
      if (c3 < c1) begin
        t = c1; c1 = c3; c3 = t;
      end
      if (c4 < c2) begin
        t = c2; c2 = c4; c4 = t;
      end
      cmd_quad(CmdHorzWin, c3, c1);
      cmd_quad(CmdVertWin, c4, c2);
      if (panel_cfg.rotated_mode) c2 = c4;
      cmd_quad(CmdCursor, c2, c1);
      bus_write(1'b0, ByteZero);
      bus_write(1'b0, CmdDraw);
    end
    pending_writes[pending_writes.size()-1].last = 1'b1;
  endfunction

  function automatic step_t rect_row(input int sc, input int sr, input int ec, input int er);
    step_t s;
    s = '0;
    s.item.kind = KindRect;
    s.item.start_col = sc[7:0];
    s.item.start_row = sr[7:0];
    s.item.end_col = ec[7:0];
    s.item.end_row = er[7:0];
    s.item.pixel_a = 16'hdead;
    s.item.pixel_b = 16'hbeef;
    return s;
  endfunction

  function automatic step_t pix_row(input logic [15:0] a, input logic [15:0] b,
                                    input logic [31:0] word);
    step_t s;
    s = '0;
    s.item = {KindPixel, 8'ha5, 8'h5a, 8'hc3, 8'h3c, a, b};
    s.typed = 1'b1;
    s.word = word;
    return s;
  endfunction

  function automatic step_t reg_row(input cfg_reg_e idx, input logic [CfgW-1:0] value);
    step_t s;
    s = '0;
    s.is_write = 1'b1;
    s.reg_idx = idx;
    s.reg_val = value;
    return s;
  endfunction

  function automatic in_item_t random_item();
    in_item_t    it;
    int unsigned sel;
    it.kind = ($urandom_range(99) < 40) ? KindRect : KindPixel;
    it.start_col = CoordW'($urandom_range(255));
    it.start_row = CoordW'($urandom_range(255));
    it.end_col = CoordW'($urandom_range(255));
    it.end_row = CoordW'($urandom_range(255));
    it.pixel_a = PixelW'($urandom_range(65535));
    it.pixel_b = PixelW'($urandom_range(65535));
    sel = $urandom_range(9);
    if (it.kind == KindRect && sel < 6) begin
      it.start_col = CoordW'($urandom_range(200));
      it.start_row = CoordW'($urandom_range(200));
      it.end_col = CoordW'($urandom_range(255, int'(it.start_col) + 1));
      it.end_row = CoordW'($urandom_range(255, int'(it.start_row) + 1));
    end else if (it.kind == KindRect && sel == 6) begin
      it.start_col = $urandom_range(1) ? 8'hff : 8'h00;
      it.start_row = $urandom_range(1) ? 8'hff : 8'h00;
      it.end_col = $urandom_range(1) ? 8'hff : 8'h00;
      it.end_row = $urandom_range(1) ? 8'hff : 8'h00;
    end
    return it;
  endfunction

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      mismatches++;
      $display("%0t %s mismatch: expected %0h actual %0h", $time, name, want, got);
    end
  endtask

  always @(posedge clk_i) begin
    out_item_t want;
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (pending_writes.size() == 0) begin
        mismatches++;
        $display("%0t unexpected transaction: expected none actual %h", $time, out_if.data);
      end else begin
        want = pending_writes.pop_front();
        check_field("is_pixel", 32'(want.is_pixel), 32'(out_if.data.is_pixel));
        check_field("high_select", 32'(want.high_select), 32'(out_if.data.high_select));
        check_field("bus_byte", 32'(want.bus_byte), 32'(out_if.data.bus_byte));
        check_field("pixel_word", want.pixel_word, out_if.data.pixel_word);
        check_field("last", 32'(want.last), 32'(out_if.data.last));
      end
    end
  end

  task automatic send_item(input in_item_t it, input logic typed, input logic [31:0] word);
    out_item_t r;
    @(negedge clk_i);
    while ($urandom_range(99) < idle_pct) begin
      in_if.valid <= 1'b0;
      @(negedge clk_i);
    end
    in_if.valid <= 1'b1;
    in_if.data <= it;
    do @(posedge clk_i); while (!in_if.ready);
    if (typed) begin
      r = '0;
      r.is_pixel = 1'b1;
      r.pixel_word = word;
      r.last = 1'b1;
      pending_writes.push_back(r);
    end else begin
      lcd_writes_for(it);
    end
  endtask

  task automatic settle();
    @(negedge clk_i);
    in_if.valid <= 1'b0;
    while (pending_writes.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(input cfg_reg_e idx, input logic [CfgW-1:0] value);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= value;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      REG_PANEL_TYPE:   panel_cfg.panel_type = value[0];
      REG_ROTATED_MODE: panel_cfg.rotated_mode = value[0];
      REG_PANEL_WIDTH:  panel_cfg.panel_width = value;
      default: ;
    endcase
  endtask

  initial begin
    #5_000_000;
    $display("lcd_window_setup_pixel_pack regression: fail");
    $finish;
  end

  initial begin
    int unsigned p, i;
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = REG_PANEL_TYPE;
    cfg_wdata_i = '0;
    in_if.valid = 1'b0;
    in_if.data = '0;
    out_if.ready = 1'b0;
    panel_cfg = '{panel_type: PanelTwoByte, rotated_mode: 1'b0, panel_width: PanelWidthRst};

    dir_steps = '{
      pix_row(16'h0000, 16'h0000, 32'h0000_0000),
      pix_row(16'hffff, 16'hffff, 32'hffff_ffff),
      pix_row(16'h1234, 16'habcd, 32'hcdab_3412),
      rect_row(10, 20, 100, 150),
      rect_row(0, 0, 0, 0),
      rect_row(255, 255, 255, 255),
      reg_row(REG_ROTATED_MODE, 8'd1),
      rect_row(0, 0, 255, 255),
      reg_row(REG_PANEL_WIDTH, 8'd1),
      rect_row(255, 255, 0, 0),
      reg_row(REG_PANEL_WIDTH, 8'd0),
      rect_row(5, 5, 10, 10),
      reg_row(REG_PANEL_TYPE, 8'd1),
      rect_row(0, 0, 0, 0),
      rect_row(200, 10, 30, 240),
      reg_row(REG_ROTATED_MODE, 8'd0),
      reg_row(REG_PANEL_WIDTH, 8'd255),
      rect_row(10, 20, 100, 150),
      rect_row(100, 150, 10, 20),
      rect_row(255, 255, 255, 255),
      pix_row(16'h00ff, 16'hff00, 32'h00ff_ff00),
      reg_row(REG_PANEL_TYPE, 8'd0),
      reg_row(REG_ROTATED_MODE, 8'd1),
      rect_row(255, 0, 0, 255),
      pix_row(16'ha5c3, 16'h5a3c, 32'h3c5a_c3a5)
    };

    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (dir_steps[k]) begin
      if (dir_steps[k].is_write) begin
        settle();
        write_reg(dir_steps[k].reg_idx, dir_steps[k].reg_val);
      end else begin
        send_item(dir_steps[k].item, dir_steps[k].typed, dir_steps[k].word);
      end
    end

    for (p = 0; p < 8; p++) begin
      settle();
      write_reg(REG_PANEL_TYPE, CfgW'(p[0] ^ p[2]));
      write_reg(REG_ROTATED_MODE, CfgW'(p[1] ^ p[2]));
      write_reg(REG_PANEL_WIDTH, (p == 2) ? 8'd1 : (p == 5) ? 8'd255 : (p == 6) ? 8'd0 :
                                 CfgW'($urandom_range(255, 1)));
      case (p % 4)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 60; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 60; end
        default: begin idle_pct = 11; stall_pct = 11; end
      endcase
      for (i = 0; i < 24; i++) begin
        // hold off until the pipeline has drained
        if (p == 1 && i == 13) settle();
        send_item(random_item(), 1'b0, '0);
      end
    end

    settle();
    if (mismatches == 0) begin
      $display("lcd_window_setup_pixel_pack regression: pass");
    end else begin
      $display("lcd_window_setup_pixel_pack regression: fail");
    end
    $finish;
  end

endmodule
